// ===== design/dhcprp_pkg.sv =====
// Shared types and constants for the DHCP request option parser.
// No dependencies; every other design file refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package dhcprp_pkg;

  localparam int unsigned FIXED_HEADER_BYTES = 236;
  localparam int unsigned MAX_MESSAGE_BYTES  = 2048;
  localparam int unsigned POS_W              = 12;

  localparam logic [31:0] MAGIC_COOKIE  = 32'h6382_5363;
  localparam logic [7:0]  OP_REQUEST    = 8'd1;
  localparam logic [7:0]  TYPE_DISCOVER = 8'd1;
  localparam logic [7:0]  TYPE_REQUEST  = 8'd3;
  localparam logic [7:0]  OPT_PAD       = 8'd0;
  localparam logic [7:0]  OPT_REQ_ADDR  = 8'd50;
  localparam logic [7:0]  OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0]  OPT_END       = 8'd255;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_OP    = 3'd1;
  localparam logic [2:0] STAT_BAD_COOKIE = 3'd2;
  localparam logic [2:0] STAT_BAD_TYPE  = 3'd3;
  localparam logic [2:0] STAT_TRUNCATED = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  dhcp_kind;
    logic        type_present;
    logic [31:0] requested_ip;
    logic        address_present;
  } result_t;

endpackage

`default_nettype wire

// ===== design/dhcprp_core.sv =====
// Per-byte parse state machine: header, cookie and option TLV walk.
// Depends on dhcprp_pkg; emits one result on the accepted last byte.
`timescale 1ns / 1ps
`default_nettype none

module dhcprp_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  dhcprp_pkg::item_t    item,
  output logic                 res_valid,
  output dhcprp_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COOKIE,
    PH_CODE,
    PH_LEN,
    PH_DATA,
    PH_DONE
  } phase_t;

  logic [dhcprp_pkg::POS_W-1:0] byte_position, byte_position_next;
  phase_t                       phase, phase_next;
  logic [7:0]                   current_option, current_option_next;
  logic [7:0]                   option_bytes_left, option_bytes_left_next;
  logic [7:0]                   payload_offset, payload_offset_next;
  logic [7:0]                   held_type, held_type_next;
  logic                         held_type_seen, held_type_seen_next;
  logic [31:0]                  held_address, held_address_next;
  logic                         held_address_seen, held_address_seen_next;
  logic [2:0]                   first_fault, first_fault_next;

  logic [1:0] cookie_idx;
  logic [7:0] cookie_byte;
  logic [7:0] bytes_left_dec;
  logic [7:0] b;

  assign b              = item.data_byte;
  assign cookie_idx     = 2'(byte_position - dhcprp_pkg::POS_W'(dhcprp_pkg::FIXED_HEADER_BYTES));
  assign bytes_left_dec = option_bytes_left - 8'd1;

  always_comb begin
    case (cookie_idx)
      2'd0:    cookie_byte = dhcprp_pkg::MAGIC_COOKIE[31:24];
      2'd1:    cookie_byte = dhcprp_pkg::MAGIC_COOKIE[23:16];
      2'd2:    cookie_byte = dhcprp_pkg::MAGIC_COOKIE[15:8];
      default: cookie_byte = dhcprp_pkg::MAGIC_COOKIE[7:0];
    endcase
  end

  always_comb begin
    byte_position_next     = byte_position;
    phase_next             = phase;
    current_option_next    = current_option;
    option_bytes_left_next = option_bytes_left;
    payload_offset_next    = payload_offset;
    held_type_next         = held_type;
    held_type_seen_next    = held_type_seen;
    held_address_next      = held_address;
    held_address_seen_next = held_address_seen;
    first_fault_next       = first_fault;
    res_valid              = 1'b0;
    res                    = '0;

    if (accept) begin
      if (byte_position < dhcprp_pkg::POS_W'(dhcprp_pkg::MAX_MESSAGE_BYTES)) begin
        byte_position_next = byte_position + dhcprp_pkg::POS_W'(1);
        case (phase)
          PH_HEADER: begin
            if (byte_position >= dhcprp_pkg::POS_W'(dhcprp_pkg::FIXED_HEADER_BYTES - 1)) begin
              phase_next = PH_COOKIE;
            end
            if (byte_position == '0 && b != dhcprp_pkg::OP_REQUEST) begin
              if (first_fault == dhcprp_pkg::STAT_OK) first_fault_next = dhcprp_pkg::STAT_BAD_OP;
              phase_next = PH_DONE;
            end
          end
          PH_COOKIE: begin
            if (cookie_idx == 2'd3) phase_next = PH_CODE;
            if (b != cookie_byte) begin
              if (first_fault == dhcprp_pkg::STAT_OK) begin
                first_fault_next = dhcprp_pkg::STAT_BAD_COOKIE;
              end
              phase_next = PH_DONE;
            end
          end
          PH_CODE: begin
            if (b == dhcprp_pkg::OPT_END) begin
              phase_next = PH_DONE;
            end else if (b != dhcprp_pkg::OPT_PAD) begin
              current_option_next = b;
              phase_next          = PH_LEN;
            end
          end
          PH_LEN: begin
            option_bytes_left_next = b;
            payload_offset_next    = 8'd0;
            phase_next             = (b == 8'd0) ? PH_CODE : PH_DATA;
            if (current_option == dhcprp_pkg::OPT_REQ_ADDR) begin
              // short address option is skipped without touching the held value
              if (b >= 8'd4) begin
                held_address_next      = 32'd0;
                held_address_seen_next = 1'b0;
              end else begin
                current_option_next = 8'd0;
              end
            end
          end
          PH_DATA: begin
            if (payload_offset != 8'd255) payload_offset_next = payload_offset + 8'd1;
            option_bytes_left_next = bytes_left_dec;
            if (bytes_left_dec == 8'd0) phase_next = PH_CODE;
            if (current_option == dhcprp_pkg::OPT_REQ_ADDR && payload_offset < 8'd4) begin
              held_address_next = {held_address[23:0], b};
              if (payload_offset == 8'd3) held_address_seen_next = 1'b1;
            end
            if (current_option == dhcprp_pkg::OPT_MSG_TYPE && payload_offset == 8'd0) begin
              held_type_next      = b;
              held_type_seen_next = 1'b1;
              if (b != dhcprp_pkg::TYPE_DISCOVER && b != dhcprp_pkg::TYPE_REQUEST) begin
                if (first_fault == dhcprp_pkg::STAT_OK) begin
                  first_fault_next = dhcprp_pkg::STAT_BAD_TYPE;
                end
                phase_next = PH_DONE;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (item.last_byte) begin
        res_valid = 1'b1;
        if (first_fault_next != dhcprp_pkg::STAT_OK) begin
          res.status = first_fault_next;
        end else if (phase_next inside {PH_HEADER, PH_COOKIE, PH_LEN, PH_DATA}) begin
          res.status = dhcprp_pkg::STAT_TRUNCATED;
        end else begin
          res.status = dhcprp_pkg::STAT_OK;
        end
        res.dhcp_kind       = held_type_seen_next ? held_type_next : 8'd0;
        res.type_present    = held_type_seen_next;
        res.requested_ip    = held_address_seen_next ? held_address_next : 32'd0;
        res.address_present = held_address_seen_next;

        // rearm for the next message
        byte_position_next     = '0;
        phase_next             = PH_HEADER;
        current_option_next    = 8'd0;
        option_bytes_left_next = 8'd0;
        payload_offset_next    = 8'd0;
        held_type_next         = 8'd0;
        held_type_seen_next    = 1'b0;
        held_address_next      = 32'd0;
        held_address_seen_next = 1'b0;
        first_fault_next       = dhcprp_pkg::STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      phase             <= PH_HEADER;
      current_option    <= 8'd0;
      option_bytes_left <= 8'd0;
      payload_offset    <= 8'd0;
      held_type         <= 8'd0;
      held_type_seen    <= 1'b0;
      held_address      <= 32'd0;
      held_address_seen <= 1'b0;
      first_fault       <= dhcprp_pkg::STAT_OK;
    end else begin
      byte_position     <= byte_position_next;
      phase             <= phase_next;
      current_option    <= current_option_next;
      option_bytes_left <= option_bytes_left_next;
      payload_offset    <= payload_offset_next;
      held_type         <= held_type_next;
      held_type_seen    <= held_type_seen_next;
      held_address      <= held_address_next;
      held_address_seen <= held_address_seen_next;
      first_fault       <= first_fault_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/dhcprp_obuf.sv =====
// Result register with a one-entry skid stage behind it.
// Depends on dhcprp_pkg; input ready comes from the skid slot being free.
`timescale 1ns / 1ps
`default_nettype none

module dhcprp_obuf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  dhcprp_pkg::result_t  push_data,
  output logic                 space,
  output logic                 result_valid,
  input  wire                  result_ready,
  output dhcprp_pkg::result_t  result
);

  logic                out_valid;
  dhcprp_pkg::result_t out_data;
  logic                skid_valid;
  dhcprp_pkg::result_t skid_data;
  logic                pop;

  assign pop          = out_valid && result_ready;
  assign space        = !skid_valid;
  assign result_valid = out_valid;
  assign result       = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      // skid and push never coincide: the input stalls while skid is full
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/dhcp_request_option_parser.sv =====
// DHCP request option parser: takes one message byte per cycle, reports on the last byte.
// The result is registered in the result register, or in the skid stage while that register is held by back-pressure.
// Throughput: one byte per cycle; the parse state updates in the accepting cycle.
// Input stalls only when the result register and its one-entry skid are both full.
// Reset (rst, synchronous): parser returns to the fixed header phase, no result pending.
// Depends on dhcprp_pkg, dhcprp_core and dhcprp_obuf.
`timescale 1ns / 1ps
`default_nettype none

module dhcp_request_option_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  dhcprp_pkg::item_t    item,
  output logic                 result_valid,
  input  wire                  result_ready,
  output dhcprp_pkg::result_t  result
);

  logic                accept;
  logic                core_valid;
  dhcprp_pkg::result_t core_result;
  logic                space;

  assign item_ready = space;
  assign accept     = item_valid && space;

  dhcprp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .res_valid (core_valid),
    .res       (core_result)
  );

  dhcprp_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (core_valid),
    .push_data    (core_result),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== design/dhcprp_checker.sv =====
// Port-level checks for the DHCP request option parser, bound to the top level.
// Depends on dhcprp_pkg and dhcp_request_option_parser.
`timescale 1ns / 1ps
`default_nettype none

module dhcprp_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 result_valid,
  input wire                 result_ready,
  input dhcprp_pkg::result_t result
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= dhcprp_pkg::STAT_TRUNCATED)
    else $error("status out of range");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.type_present || result.dhcp_kind == 8'd0) &&
                     (result.address_present || result.requested_ip == 32'd0))
    else $error("absent field not zero");

  a_ok_type: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == dhcprp_pkg::STAT_OK |->
      !result.type_present ||
      result.dhcp_kind == dhcprp_pkg::TYPE_DISCOVER ||
      result.dhcp_kind == dhcprp_pkg::TYPE_REQUEST)
    else $error("accepted message with unsupported type");

endmodule

bind dhcp_request_option_parser dhcprp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire
